// ===== rtl/euler_yxz_to_quaternion_top_assert.svh =====
// assertion macros shared by the euler to quaternion rtl
`ifndef EULER_YXZ_TO_QUATERNION_TOP_ASSERT_SVH
`define EULER_YXZ_TO_QUATERNION_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define EYQ_ASSERT_SAME(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("%m: check failed");

// condition implies consequence in the next cycle
`define EYQ_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== rtl/euyq_pkg.sv =====
// shared types, constants and tables for the euler to quaternion block
package euyq_pkg;

	localparam int unsigned ANGLE_FRAC_BITS_DEF = 13;
	localparam int unsigned OUT_FRAC_BITS_DEF   = 14;
	localparam int unsigned CORDIC_STAGES_DEF   = 16;

	localparam int unsigned CW = 34;  // cordic datapath width, q2.30 plus headroom
	localparam int unsigned HW = 40;  // width of an unreduced half angle
	localparam int unsigned MAX_TURNS = 3;

	localparam logic signed [HW-1:0] PI_Q30      = 40'sd3373259426;
	localparam logic signed [HW-1:0] HALF_PI_Q30 = 40'sd1686629713;
	localparam logic signed [HW-1:0] TWO_PI_Q30  = 40'sd6746518852;
	localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 neg;
	} axis_t;

	// one entry per angle: 0 is x, 1 is y, 2 is z
	typedef struct packed {
		axis_t [2:0] ax;
	} trio_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0:  r = 32'd843314856;
				5'd1:  r = 32'd497837829;
				5'd2:  r = 32'd263043836;
				5'd3:  r = 32'd133525158;
				5'd4:  r = 32'd67021686;
				5'd5:  r = 32'd33543515;
				5'd6:  r = 32'd16775850;
				5'd7:  r = 32'd8388437;
				5'd8:  r = 32'd4194282;
				5'd9:  r = 32'd2097149;
				5'd10: r = 32'd1048575;
				5'd11: r = 32'd524287;
				5'd12: r = 32'd262143;
				5'd13: r = 32'd131071;
				5'd14: r = 32'd65535;
				5'd15: r = 32'd32767;
				5'd16: r = 32'd16383;
				5'd17: r = 32'd8191;
				5'd18: r = 32'd4095;
				5'd19: r = 32'd2047;
				5'd20: r = 32'd1023;
				5'd21: r = 32'd511;
				5'd22: r = 32'd255;
				5'd23: r = 32'd127;
				5'd24: r = 32'd63;
				5'd25: r = 32'd31;
				5'd26: r = 32'd15;
				5'd27: r = 32'd7;
				5'd28: r = 32'd3;
				5'd29: r = 32'd1;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

	// fold a q2.30 half angle into [-pi/2, pi/2] and load the cordic start values
	function automatic axis_t init_axis(input logic signed [HW-1:0] h_in);
		logic signed [HW-1:0] h;
		axis_t a;
		begin
			h = h_in;
			for (int t = 0; t < MAX_TURNS; t++) begin
				if (h > PI_Q30)
					h = h - TWO_PI_Q30;
				else if (h < -PI_Q30)
					h = h + TWO_PI_Q30;
			end
			a.neg = 1'b0;
			if (h > HALF_PI_Q30) begin
				h = h - PI_Q30;
				a.neg = 1'b1;
			end else if (h < -HALF_PI_Q30) begin
				h = h + PI_Q30;
				a.neg = 1'b1;
			end
			a.x = GAIN_Q30;
			a.y = '0;
			a.z = h[CW-1:0];
			return a;
		end
	endfunction

endpackage

// ===== rtl/euyq_cell.sv =====
// one cordic rotation step for all three angles
module euyq_cell #(
	parameter int unsigned STAGE = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  euyq_pkg::trio_t d_in,
	output logic            vld_s1,
	output euyq_pkg::trio_t d_s1
);
	import euyq_pkg::*;

	logic signed [CW-1:0] ang;
	trio_t nxt;

	assign ang = $signed({{(CW-32){1'b0}}, atan_q30(5'(STAGE))});

	always_comb begin
		nxt = d_in;
		for (int a = 0; a < 3; a++) begin
			if (!d_in.ax[a].z[CW-1]) begin
				nxt.ax[a].x = d_in.ax[a].x - (d_in.ax[a].y >>> STAGE);
				nxt.ax[a].y = d_in.ax[a].y + (d_in.ax[a].x >>> STAGE);
				nxt.ax[a].z = d_in.ax[a].z - ang;
			end else begin
				nxt.ax[a].x = d_in.ax[a].x + (d_in.ax[a].y >>> STAGE);
				nxt.ax[a].y = d_in.ax[a].y - (d_in.ax[a].x >>> STAGE);
				nxt.ax[a].z = d_in.ax[a].z + ang;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nxt;
		end
	end

endmodule

// ===== rtl/euyq_combine.sv =====
// quaternion products, rounding, saturation and output register
`include "euler_yxz_to_quaternion_top_assert.svh"
module euyq_combine #(
	parameter int unsigned OUT_FRAC_BITS = euyq_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_in,
	input  euyq_pkg::trio_t    d_in,
	output logic               out_valid,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);
	import euyq_pkg::*;

	localparam int unsigned PW = 2 * CW;
	localparam int unsigned SW = PW + 1;
	localparam logic signed [SW-1:0] LIM =
		(OUT_FRAC_BITS >= 15) ? SW'(32767) : SW'(1) <<< OUT_FRAC_BITS;
	localparam logic signed [SW-1:0] RND = SW'(1) <<< (59 - OUT_FRAC_BITS);

	logic signed [CW-1:0] cx, sx, cy, sy, cz, sz;
	logic signed [PW-1:0] p_cycx, p_sysx, p_cysx, p_sycx;
	logic signed [CW-1:0] cycx_s1, sysx_s1, cysx_s1, sycx_s1, cz_s1, sz_s1;
	logic signed [PW-1:0] a_s2, b_s2, c_s2, d_s2, e_s2, f_s2, g_s2, h_s2;
	logic signed [15:0]   fx, fy, fz, fw;
	logic                 vld_s1, vld_s2;

	function automatic logic signed [15:0] finish(input logic signed [SW-1:0] q60);
		logic signed [SW-1:0] v;
		begin
			v = (q60 + RND) >>> (60 - OUT_FRAC_BITS);
			if (v > LIM)
				v = LIM;
			else if (v < -LIM)
				v = -LIM;
			return v[15:0];
		end
	endfunction

	function automatic logic signed [CW-1:0] rnd30(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] r;
		begin
			r = (p + (PW'(1) <<< 29)) >>> 30;
			return r[CW-1:0];
		end
	endfunction

	// undo the half-turn fold
	assign cx = d_in.ax[0].neg ? -d_in.ax[0].x : d_in.ax[0].x;
	assign sx = d_in.ax[0].neg ? -d_in.ax[0].y : d_in.ax[0].y;
	assign cy = d_in.ax[1].neg ? -d_in.ax[1].x : d_in.ax[1].x;
	assign sy = d_in.ax[1].neg ? -d_in.ax[1].y : d_in.ax[1].y;
	assign cz = d_in.ax[2].neg ? -d_in.ax[2].x : d_in.ax[2].x;
	assign sz = d_in.ax[2].neg ? -d_in.ax[2].y : d_in.ax[2].y;

	assign p_cycx = cy * cx;
	assign p_sysx = sy * sx;
	assign p_cysx = cy * sx;
	assign p_sycx = sy * cx;

	assign fx = finish(SW'(a_s2) + SW'(b_s2));
	assign fy = finish(SW'(c_s2) - SW'(d_s2));
	assign fz = finish(SW'(e_s2) - SW'(f_s2));
	assign fw = finish(SW'(g_s2) + SW'(h_s2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= vld_in;
			vld_s2    <= vld_s1;
			out_valid <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cycx_s1 <= rnd30(p_cycx);
			sysx_s1 <= rnd30(p_sysx);
			cysx_s1 <= rnd30(p_cysx);
			sycx_s1 <= rnd30(p_sycx);
			cz_s1   <= cz;
			sz_s1   <= sz;
			a_s2    <= cysx_s1 * cz_s1;
			b_s2    <= sycx_s1 * sz_s1;
			c_s2    <= sycx_s1 * cz_s1;
			d_s2    <= cysx_s1 * sz_s1;
			e_s2    <= cycx_s1 * sz_s1;
			f_s2    <= sysx_s1 * cz_s1;
			g_s2    <= cycx_s1 * cz_s1;
			h_s2    <= sysx_s1 * sz_s1;
			quat_x  <= fx;
			quat_y  <= fy;
			quat_z  <= fz;
			quat_w  <= fw;
		end
	end

	`EYQ_ASSERT_NEXT(a_vld_walk, en && vld_in, vld_s1)
	`EYQ_ASSERT_NEXT(a_vld_out, en && vld_s2, out_valid)
	`EYQ_ASSERT_SAME(a_w_range, out_valid, (17'(quat_w) <= 17'(LIM)) || (quat_w[15] == 1'b1))
	`EYQ_ASSERT_SAME(a_x_range, out_valid, (-17'(quat_x) <= 17'(LIM)) || (quat_x[15] == 1'b0))

endmodule

// ===== rtl/euler_yxz_to_quaternion_top.sv =====
// Euler angles (order R = Ry*Rx*Rz) to unit quaternion, one transaction per
// clock cycle while the output is not stalled; the pipeline is an input
// register, a chain of cordic cells, one per rotation step, two multiply
// stages and the output register. The whole pipeline advances whenever the
// output register is empty or being taken, so a stalled output holds every stage.
`include "euler_yxz_to_quaternion_top_assert.svh"
module euler_yxz_to_quaternion_top #(
	parameter int unsigned ANGLE_FRAC_BITS = euyq_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int unsigned OUT_FRAC_BITS   = euyq_pkg::OUT_FRAC_BITS_DEF,
	parameter int unsigned CORDIC_STAGES   = euyq_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);
	import euyq_pkg::*;

	localparam int unsigned SH = 29 - ANGLE_FRAC_BITS;

	logic  en;
	logic  vld_s0;
	trio_t d_s0;
	logic  vld_c [CORDIC_STAGES+1];
	trio_t d_c   [CORDIC_STAGES+1];

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s0.ax[0] <= init_axis(HW'(angle_x) <<< SH);
			d_s0.ax[1] <= init_axis(HW'(angle_y) <<< SH);
			d_s0.ax[2] <= init_axis(HW'(angle_z) <<< SH);
		end
	end

	assign vld_c[0] = vld_s0;
	assign d_c[0]   = d_s0;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		euyq_cell #(.STAGE(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (vld_c[g]),
			.d_in   (d_c[g]),
			.vld_s1 (vld_c[g+1]),
			.d_s1   (d_c[g+1])
		);
	end

	euyq_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_in    (vld_c[CORDIC_STAGES]),
		.d_in      (d_c[CORDIC_STAGES]),
		.out_valid (out_valid),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.quat_w    (quat_w)
	);

	`EYQ_ASSERT_NEXT(a_take_s0, in_valid && in_ready, vld_s0)
	`EYQ_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(quat_w))
	`EYQ_ASSERT_NEXT(a_first_cell, en && vld_s0, vld_c[1])

endmodule
